// File: design/dtcr_pkg.sv
// Package for the tag-chain DMA receiver: request codes, state and result types, constants.
`default_nettype none
package dtcr_pkg;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    FUNC_WORD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_CLEAR = 2'd2
  } dtcr_func_e;

  localparam int unsigned FLAG_W       = 6;
  localparam int unsigned COUNT_W      = 16;
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned TAG_FIELD_W  = 24;
  localparam int unsigned COMPLETE_BIT = 3;
  localparam int unsigned IRQ_BIT      = 30;
  localparam int unsigned END_BIT      = 31;
  localparam int unsigned CLR_LO       = 24;

  localparam logic [1:0]         TAG_ADDR_IDX = 2'd0;
  localparam logic [1:0]         TAG_SIZE_IDX = 2'd1;
  localparam logic [ADDR_W-1:0]  ADDR_STEP    = 32'd4;
  localparam logic [COUNT_W-1:0] SIZE_ROUND   = 16'd3;
  localparam logic [COUNT_W-1:0] COUNT_ALIGN  = 16'hfffc;
  localparam logic [FLAG_W-1:0]  COMPLETE_FLAG = FLAG_W'(1) << COMPLETE_BIT;

  // Channel state
  typedef struct packed {
    logic               running;
    logic [1:0]         tag_idx;
    logic [COUNT_W-1:0] words_left;
    logic [ADDR_W-1:0]  next_addr;
    logic               tag_irq;
    logic               tag_end;
    logic [FLAG_W-1:0]  done_flags;
  } dtcr_state_t;

  // One result item
  typedef struct packed {
    logic              write_valid;
    logic [ADDR_W-1:0] write_addr;
    logic [DATA_W-1:0] write_data;
    logic              done_res;
    logic              irq_pulse;
    logic [FLAG_W-1:0] flags_now;
    logic              busy_res;
  } dtcr_result_t;

endpackage
`default_nettype wire

// File: design/dma_tag_chain_receiver_unit.sv
// Top level of the tag-chain DMA receiver: input stage, channel state, result register.
//
//  channel  | signals                    | carries
//  ---------+----------------------------+--------------------------------------
//  s_axis   | tvalid/tready/tuser/tdata  | request: tuser=func, tdata=word
//  m_axis   | tvalid/tready/tuser/tdata  | result: tuser=write_valid, tdata=rest
//  cfg      | cfg_we_i/cfg_wdata_i       | irq_mask write, no read-back
//
// Each request passes from acceptance through the input register, then through
// one pass of the step logic into the result register.
// Sustained rate is one request per cycle unless m_axis stalls; the update is one pass.
// Reset (rst_ni low, asynchronous) clears the channel state, mask and valids.
// A stall at m_axis holds the result; the input register then holds one more
// request and s_axis_tready drops.
`default_nettype none
module dma_tag_chain_receiver_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
  input  wire logic [31:0] s_axis_tdata,   // [31:0] word
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [0:0]  m_axis_tuser,   // [0] write_valid
  output      logic [79:0] m_axis_tdata,   // [31:0] write_addr, [63:32] write_data,
                                           // [64] done_res, [65] irq_pulse,
                                           // [71:66] flags_now, [72] busy_res, rest 0
  input  wire logic        cfg_we_i,
  input  wire logic [5:0]  cfg_wdata_i
);

  logic                         in_valid_q;
  logic [1:0]                   in_func_q;
  logic [dtcr_pkg::DATA_W-1:0]  in_word_q;
  logic                         out_valid_q;
  dtcr_pkg::dtcr_result_t       out_res_q;
  dtcr_pkg::dtcr_result_t       res_d;
  dtcr_pkg::dtcr_state_t        state_q, state_d;
  logic [dtcr_pkg::FLAG_W-1:0]  irq_mask_q;
  logic                         advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // Interrupt mask register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_mask_q <= '0;
    end else if (cfg_we_i) begin
      irq_mask_q <= cfg_wdata_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q <= s_axis_tuser;
      in_word_q <= s_axis_tdata;
    end
  end

  dtcr_step u_step (
    .func_i     (in_func_q),
    .word_i     (in_word_q),
    .irq_mask_i (irq_mask_q),
    .state_i    (state_q),
    .state_o    (state_d),
    .res_o      (res_d)
  );

  // Channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.write_valid;
  assign m_axis_tdata  = {7'b0, out_res_q.busy_res, out_res_q.flags_now, out_res_q.irq_pulse,
                          out_res_q.done_res, out_res_q.write_data, out_res_q.write_addr};

  // Checks
  a_done_is_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.done_res |-> out_res_q.write_valid && !out_res_q.busy_res)
    else $error("completion without a final write or with channel busy");

  a_irq_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.irq_pulse |-> out_res_q.done_res)
    else $error("interrupt pulse without completion");

  a_busy_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_res_q.busy_res == state_q.running
                && out_res_q.flags_now == state_q.done_flags)
    else $error("result status differs from channel state");

  a_data_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.write_valid |-> state_q.running && state_q.words_left != '0)
    else $error("write issued with no pending block");

endmodule
`default_nettype wire

// File: design/dtcr_step.sv
// Per-request next-state and result logic of the tag-chain receiver.
`default_nettype none
module dtcr_step (
  input  wire logic [1:0]                      func_i,
  input  wire logic [dtcr_pkg::DATA_W-1:0]     word_i,
  input  wire logic [dtcr_pkg::FLAG_W-1:0]     irq_mask_i,
  input  wire dtcr_pkg::dtcr_state_t           state_i,
  output dtcr_pkg::dtcr_state_t                state_o,
  output dtcr_pkg::dtcr_result_t               res_o
);

  logic                           data_phase;
  logic                           last_word;
  logic [dtcr_pkg::FLAG_W-1:0]    flags_set;
  logic [dtcr_pkg::COUNT_W-1:0]   size_lo;

  assign data_phase = (state_i.words_left != '0) && (state_i.tag_idx == dtcr_pkg::TAG_ADDR_IDX);
  assign last_word  = (state_i.words_left == dtcr_pkg::COUNT_W'(1))
                      && (state_i.tag_irq || state_i.tag_end);
  assign flags_set  = state_i.done_flags | dtcr_pkg::COMPLETE_FLAG;
  assign size_lo    = word_i[dtcr_pkg::COUNT_W-1:0];

  // Decode the request and update the channel
  always_comb begin
    state_o           = state_i;
    res_o             = '0;
    unique case (func_i)
      dtcr_pkg::FUNC_START: begin
        state_o.running = 1'b1;
      end
      dtcr_pkg::FUNC_CLEAR: begin
        state_o.done_flags = state_i.done_flags
                             & ~word_i[dtcr_pkg::CLR_LO +: dtcr_pkg::FLAG_W];
      end
      dtcr_pkg::FUNC_WORD: begin
        if (state_i.running) begin
          if (data_phase) begin
            // Data word of the pending block
            res_o.write_valid  = 1'b1;
            res_o.write_addr   = state_i.next_addr;
            res_o.write_data   = word_i;
            state_o.next_addr  = state_i.next_addr + dtcr_pkg::ADDR_STEP;
            state_o.words_left = state_i.words_left - dtcr_pkg::COUNT_W'(1);
            if (last_word) begin
              state_o.done_flags = flags_set;
              state_o.running    = 1'b0;
              res_o.done_res     = 1'b1;
              res_o.irq_pulse    = |(flags_set & irq_mask_i);
            end
          end else begin
            // Tag word
            if (state_i.tag_idx == dtcr_pkg::TAG_ADDR_IDX) begin
              state_o.next_addr = {{(dtcr_pkg::ADDR_W-dtcr_pkg::TAG_FIELD_W){1'b0}},
                                   word_i[dtcr_pkg::TAG_FIELD_W-1:0]};
              state_o.tag_irq   = word_i[dtcr_pkg::IRQ_BIT];
              state_o.tag_end   = word_i[dtcr_pkg::END_BIT];
            end else if (state_i.tag_idx == dtcr_pkg::TAG_SIZE_IDX) begin
              state_o.words_left = (size_lo + dtcr_pkg::SIZE_ROUND) & dtcr_pkg::COUNT_ALIGN;
            end
            state_o.tag_idx = state_i.tag_idx + 2'd1;
          end
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
    res_o.flags_now = state_o.done_flags;
    res_o.busy_res  = state_o.running;
  end

endmodule
`default_nettype wire
